[sv/ps2mc_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the PS/2 mouse packet cursor block.
// No dependencies.
package ps2mc_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int CFG_BITS       = 13;
    localparam int CFG_IDX_BITS   = 1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_HEIGHT = 1'b1;

    localparam logic [CFG_BITS-1:0] WIDTH_RST  = 13'd1024;
    localparam logic [CFG_BITS-1:0] HEIGHT_RST = 13'd768;

    localparam int STAT_READY_BIT = 0;
    localparam int STAT_AUX_BIT   = 5;
    localparam int SYNC_BIT       = 3;
    localparam int BTN_LEFT_BIT   = 0;
    localparam int BTN_RIGHT_BIT  = 1;

    typedef enum logic [2:0] {
        POS_FLAG = 3'b001,
        POS_XDLT = 3'b010,
        POS_YDLT = 3'b100
    } byte_pos_t;

endpackage

[sv/ps2_mouse_packet_cursor_top.sv]
`timescale 1ns / 1ps
// PS/2 poll decoder: keyboard pass-through, three-byte mouse packets, cursor.
// Depends on ps2mc_pkg and ps2mc_clamp.
//
// Takes one controller poll (status and data byte) per cycle and returns one
// result per poll. The poll is captured in the input register at its transfer,
// and the decode/move/clamp logic loads the result register from it once that
// register is empty or being taken, which raises m_valid.
// Throughput is one poll per clock while m_ready is high; a stalled result
// holds the pipeline. The user writes screen width/height via the cfg port
// only while idle (not enforced); they apply at the next completed packet.
module ps2_mouse_packet_cursor_top #(
    parameter int COORD_BITS = ps2mc_pkg::COORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_wr_en,
    input  logic [ps2mc_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [ps2mc_pkg::CFG_BITS-1:0] cfg_data,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_ctrl_status,
    input  logic [7:0]                    s_ctrl_data,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_key_code,
    output logic [COORD_BITS-1:0]         m_cursor_x,
    output logic [COORD_BITS-1:0]         m_cursor_y,
    output logic                          m_packet_done,
    output logic                          m_left_pressed,
    output logic                          m_right_pressed
);
    import ps2mc_pkg::*;

    logic [CFG_BITS-1:0]   width_reg;
    logic [CFG_BITS-1:0]   height_reg;

    logic                  in_valid_reg;
    logic [7:0]            in_status_reg;
    logic [7:0]            in_data_reg;

    byte_pos_t             pos_reg, pos_next;
    logic [7:0]            flag_reg, flag_next;
    logic [7:0]            xdlt_reg, xdlt_next;
    logic [COORD_BITS-1:0] px_reg, px_next;
    logic [COORD_BITS-1:0] py_reg, py_next;

    logic                  out_valid_reg;
    logic [7:0]            key_reg, key_next;
    logic [COORD_BITS-1:0] ox_reg;
    logic [COORD_BITS-1:0] oy_reg;
    logic                  done_reg, done_next;
    logic                  left_reg, left_next;
    logic                  right_reg, right_next;

    logic                  adv;
    logic signed [8:0]     dx;
    logic signed [8:0]     dy;
    logic [COORD_BITS-1:0] mx;
    logic [COORD_BITS-1:0] my;

    assign adv     = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;

    assign dx = 9'(signed'(xdlt_reg));
    assign dy = 9'sd0 - 9'(signed'(in_data_reg));

    ps2mc_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_x (
        .pos     (px_reg),
        .delta   (dx),
        .size    (width_reg),
        .pos_new (mx)
    );

    ps2mc_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_y (
        .pos     (py_reg),
        .delta   (dy),
        .size    (height_reg),
        .pos_new (my)
    );

    always_comb begin
        pos_next   = pos_reg;
        flag_next  = flag_reg;
        xdlt_next  = xdlt_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        key_next   = '0;
        done_next  = 1'b0;
        left_next  = 1'b0;
        right_next = 1'b0;
        if (in_status_reg[STAT_READY_BIT]) begin
            if (in_status_reg[STAT_AUX_BIT]) begin
                unique case (pos_reg)
                    POS_FLAG: begin
                        if (in_data_reg[SYNC_BIT]) begin
                            flag_next = in_data_reg;
                            pos_next  = POS_XDLT;
                        end
                    end
                    POS_XDLT: begin
                        xdlt_next = in_data_reg;
                        pos_next  = POS_YDLT;
                    end
                    default: begin
                        pos_next   = POS_FLAG;
                        px_next    = mx;
                        py_next    = my;
                        done_next  = 1'b1;
                        left_next  = flag_reg[BTN_LEFT_BIT];
                        right_next = flag_reg[BTN_RIGHT_BIT];
                    end
                endcase
            end else begin
                key_next = in_data_reg;
            end
        end
    end

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_IDX_WIDTH:  width_reg  <= cfg_data;
                CFG_IDX_HEIGHT: height_reg <= cfg_data;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_status_reg <= s_ctrl_status;
            in_data_reg   <= s_ctrl_data;
        end
    end

    // decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= POS_FLAG;
            flag_reg <= '0;
            xdlt_reg <= '0;
            px_reg   <= '0;
            py_reg   <= '0;
        end else if (adv) begin
            pos_reg  <= pos_next;
            flag_reg <= flag_next;
            xdlt_reg <= xdlt_next;
            px_reg   <= px_next;
            py_reg   <= py_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            key_reg   <= key_next;
            ox_reg    <= px_next;
            oy_reg    <= py_next;
            done_reg  <= done_next;
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_key_code      = key_reg;
    assign m_cursor_x      = ox_reg;
    assign m_cursor_y      = oy_reg;
    assign m_packet_done   = done_reg;
    assign m_left_pressed  = left_reg;
    assign m_right_pressed = right_reg;

endmodule

[sv/ps2mc_clamp.sv]
`timescale 1ns / 1ps
// Moves one cursor coordinate by a signed delta and clamps it to [0, lim],
// lim = min(size-1, 2^COORD_BITS-1), size 0 as 1. Depends on ps2mc_pkg.
module ps2mc_clamp #(
    parameter int COORD_BITS = ps2mc_pkg::COORD_BITS_DEF
) (
    input  logic [COORD_BITS-1:0]         pos,
    input  logic signed [8:0]             delta,
    input  logic [ps2mc_pkg::CFG_BITS-1:0] size,
    output logic [COORD_BITS-1:0]         pos_new
);
    import ps2mc_pkg::*;

    localparam int W = ((COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS) + 2;
    localparam logic signed [W-1:0] CAP = W'((64'd1 << COORD_BITS) - 64'd1);

    logic [CFG_BITS-1:0]  size_eff;
    logic [CFG_BITS-1:0]  lim_raw;
    logic signed [W-1:0]  lim_ext;
    logic signed [W-1:0]  lim;
    logic signed [W-1:0]  sum;
    logic signed [W-1:0]  res;

    always_comb begin
        size_eff = (size == '0) ? CFG_BITS'(1) : size;
        lim_raw  = size_eff - CFG_BITS'(1);
        lim_ext  = signed'(W'(lim_raw));
        lim      = (lim_ext > CAP) ? CAP : lim_ext;
        sum      = signed'(W'({1'b0, pos})) + W'(delta);
        priority if (sum < 0) begin
            res = '0;
        end else if (sum > lim) begin
            res = lim;
        end else begin
            res = sum;
        end
        pos_new = res[COORD_BITS-1:0];
    end

endmodule
